[src/mqpi_pkg.sv]
// package of types and constants used by the queue bank top level
package mqpi_pkg;

  // command codes
  typedef enum logic [0:0] {
    CMD_ADD = 1'b0,
    CMD_POP = 1'b1
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_ADDED  = 3'd0,
    ST_FULL   = 3'd1,
    ST_POPPED = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_BADIDX = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LOOKUP = 2'd1,
    S_SERVE  = 2'd2
  } state_t;

  // input beat
  typedef struct packed {
    logic        command;
    logic [4:0]  queue_index;
    logic [15:0] entry_id;
    logic        urgent;
  } request_t;

  // result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] served_id;
    logic        served_urgent;
    logic [3:0]  occupancy;
  } result_t;

endpackage

[src/multi_queue_priority_insert_core.sv]
// top level of the bank of bounded priority-insert queues
//
// A command beat is taken when start is high and busy is low. An add or any
// rejected command passes through the accept in idle and the descriptor lookup
// state; a successful pop also passes through the serve state for the registered
// read of the entry ram. Both paths follow from the registered reads of the
// descriptor ram and the entry ram. The result appears on result for exactly
// one cycle with done high, registered from the last internal state; the
// receiver cannot stall it, and a new command may be accepted in that same
// cycle. No clearing pass is needed after reset.
module multi_queue_priority_insert_core #(
  parameter int NUM_QUEUES  = 32,
  parameter int QUEUE_DEPTH = 8,
  parameter int ID_WIDTH    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mqpi_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output mqpi_pkg::result_t  result
);

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = ((PW > CW) ? PW : CW) + 1;
  localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
  localparam int SLW   = $clog2(SLOTS);

  mqpi_pkg::state_t   state;
  mqpi_pkg::state_t   state_next;
  mqpi_pkg::request_t cur;
  logic               q_ok;
  logic               accept;
  logic               in_range;

  logic [CW-1:0]      cnt;
  logic [PW-1:0]      head;
  logic               is_add;
  logic               full;
  logic               empty;
  logic               add_ok;
  logic               pop_ok;
  logic [PW-1:0]      head_dec;
  logic [PW-1:0]      head_inc;
  logic [SW-1:0]      tail_sum;
  logic [PW-1:0]      tail;
  logic [PW-1:0]      pos;
  logic [SLW-1:0]     slot;
  logic [QW-1:0]      qaddr;

  logic               desc_we;
  logic [CW-1:0]      desc_wcount;
  logic [PW-1:0]      desc_whead;
  logic               entry_we;
  logic               entry_re;
  logic [ID_WIDTH:0]  entry_rdata;
  logic [ID_WIDTH+15:0] id_in_ext;
  logic [ID_WIDTH+15:0] id_out_ext;

  // beat accepted when idle
  assign accept   = start && !busy;
  assign in_range = int'(request.queue_index) < NUM_QUEUES;
  assign qaddr    = cur.queue_index[QW-1:0];

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cur  <= request;
      q_ok <= in_range;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mqpi_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mqpi_pkg::S_IDLE: begin
        if (accept) begin
          state_next = mqpi_pkg::S_LOOKUP;
        end
      end
      mqpi_pkg::S_LOOKUP: begin
        state_next = pop_ok ? mqpi_pkg::S_SERVE : mqpi_pkg::S_IDLE;
      end
      mqpi_pkg::S_SERVE: begin
        state_next = mqpi_pkg::S_IDLE;
      end
      default: begin
        state_next = mqpi_pkg::S_IDLE;
      end
    endcase
  end

  // descriptor store
  mqpi_desc_store #(
    .NUM_QUEUES (NUM_QUEUES),
    .CW         (CW),
    .PW         (PW),
    .QW         (QW)
  ) u_desc (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept && in_range),
    .rd_addr  (request.queue_index[QW-1:0]),
    .wr_en    (desc_we),
    .wr_addr  (qaddr),
    .wr_count (desc_wcount),
    .wr_head  (desc_whead),
    .rd_count (cnt),
    .rd_head  (head)
  );

  // decode of the looked-up descriptor
  assign is_add   = (cur.command == mqpi_pkg::CMD_ADD);
  assign full     = (int'(cnt) >= QUEUE_DEPTH);
  assign empty    = (cnt == '0);
  assign add_ok   = q_ok && is_add && !full;
  assign pop_ok   = q_ok && !is_add && !empty;

  // circular pointer arithmetic
  assign head_dec = (head == '0) ? PW'(QUEUE_DEPTH - 1) : head - PW'(1);
  assign head_inc = (int'(head) == QUEUE_DEPTH - 1) ? '0 : head + PW'(1);
  assign tail_sum = SW'(head) + SW'(cnt);
  assign tail     = (int'(tail_sum) >= QUEUE_DEPTH) ?
                    PW'(tail_sum - SW'(QUEUE_DEPTH)) : PW'(tail_sum);

  // slot of the entry touched by this command
  always_comb begin
    if (!is_add) begin
      pos = head;
    end else if (cur.urgent) begin
      pos = head_dec;
    end else begin
      pos = tail;
    end
  end
  assign slot = SLW'(int'(qaddr) * QUEUE_DEPTH + int'(pos));

  // memory controls
  always_comb begin
    desc_we     = 1'b0;
    desc_wcount = cnt;
    desc_whead  = head;
    entry_we    = 1'b0;
    entry_re    = 1'b0;
    if (state == mqpi_pkg::S_LOOKUP) begin
      if (add_ok) begin
        desc_we     = 1'b1;
        desc_wcount = cnt + CW'(1);
        desc_whead  = cur.urgent ? head_dec : head;
        entry_we    = 1'b1;
      end else if (pop_ok) begin
        desc_we     = 1'b1;
        desc_wcount = cnt - CW'(1);
        desc_whead  = head_inc;
        entry_re    = 1'b1;
      end
    end
  end

  assign busy = (state != mqpi_pkg::S_IDLE);

  // id width adaption on the way in and out
  assign id_in_ext  = {ID_WIDTH'(0), cur.entry_id};
  assign id_out_ext = {16'(0), entry_rdata[ID_WIDTH-1:0]};

  // entry store
  mqpi_ram #(
    .WIDTH (ID_WIDTH + 1),
    .DEPTH (SLOTS)
  ) u_entries (
    .clk   (clk),
    .we    (entry_we),
    .waddr (slot),
    .wdata ({cur.urgent, id_in_ext[ID_WIDTH-1:0]}),
    .re    (entry_re),
    .raddr (slot),
    .rdata (entry_rdata)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (state == mqpi_pkg::S_LOOKUP) begin
      result.served_id     <= '0;
      result.served_urgent <= 1'b0;
      if (!q_ok) begin
        result.status    <= mqpi_pkg::ST_BADIDX;
        result.occupancy <= '0;
      end else if (is_add) begin
        result.status    <= full ? mqpi_pkg::ST_FULL : mqpi_pkg::ST_ADDED;
        result.occupancy <= full ? 4'(cnt) : 4'(cnt + CW'(1));
      end else begin
        result.status    <= empty ? mqpi_pkg::ST_EMPTY : mqpi_pkg::ST_POPPED;
        result.occupancy <= empty ? 4'(0) : 4'(cnt - CW'(1));
      end
    end else if (state == mqpi_pkg::S_SERVE) begin
      result.served_id     <= id_out_ext[15:0];
      result.served_urgent <= entry_rdata[ID_WIDTH];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ((state == mqpi_pkg::S_LOOKUP) && !pop_ok) ||
              (state == mqpi_pkg::S_SERVE);
    end
  end

endmodule

[src/mqpi_ram.sv]
// generic single write port ram with registered read
module mqpi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/mqpi_desc_store.sv]
// per-queue descriptor store: count and head pointer in ram, valid bits give reset value
module mqpi_desc_store #(
  parameter int NUM_QUEUES = 32,
  parameter int CW         = 4,
  parameter int PW         = 3,
  parameter int QW         = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [QW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [QW-1:0] wr_addr,
  input  logic [CW-1:0] wr_count,
  input  logic [PW-1:0] wr_head,
  output logic [CW-1:0] rd_count,
  output logic [PW-1:0] rd_head
);

  logic [NUM_QUEUES-1:0] valid;
  logic                  rd_valid;
  logic [CW+PW-1:0]      rd_data;

  mqpi_ram #(
    .WIDTH (CW + PW),
    .DEPTH (NUM_QUEUES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({wr_count, wr_head}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // valid bits: a never written queue reads as empty with head zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // mask stale ram contents
  assign rd_count = rd_valid ? rd_data[CW+PW-1:PW] : '0;
  assign rd_head  = rd_valid ? rd_data[PW-1:0]     : '0;

endmodule
